>>> hdl/bpda_pkg.sv
`timescale 1ns / 1ps

package bpda_pkg;

  // debouncer states, one machine per key
  typedef enum logic [1:0] {
    ST_UP      = 2'd0,
    ST_FALLING = 2'd1,
    ST_DOWN    = 2'd2,
    ST_RISING  = 2'd3
  } debounce_t;

  // control value and limit registers
  localparam int unsigned VALUE_W = 10;
  localparam logic [VALUE_W-1:0] RESET_VALUE = 10'd500;
  localparam logic [VALUE_W-1:0] RESET_MIN   = 10'd100;
  localparam logic [VALUE_W-1:0] RESET_MAX   = 10'd900;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 1'b1;

  // stream payload layout
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;

  // result item field positions
  localparam int unsigned O_VALUE_LSB = 0;
  localparam int unsigned O_REL0      = 10;
  localparam int unsigned O_REL1      = 11;
  localparam int unsigned O_DUR0_LSB  = 12;
  localparam int unsigned O_DUR1_LSB  = 44;
  localparam int unsigned O_DOWN0     = 76;
  localparam int unsigned O_DOWN1     = 77;

endpackage

>>> hdl/button_press_duration_adjuster.sv
`timescale 1ns / 1ps

// channel   | dir | signals                          | content
// ----------+-----+----------------------------------+---------------------------------------
// s_        | in  | s_tvalid s_tready s_tdata[39:0]  | one debounce sample per item
// m_        | out | m_tvalid m_tready m_tdata[79:0]  | one result item per sample
// cfg_      | in  | cfg_we cfg_index cfg_wdata[9:0]  | 0 = min_value, 1 = max_value
//
// each sample passes through the input register, then the debounce,
// duration and saturation logic into the result register
// one item per cycle sustained while m_tready stays high; the next sample sees the key state left by the
// previous one, which is updated as the result register loads
// rst is synchronous: keys up, stamps and durations zero, value 500, limits 100/900
// a stalled result holds the result register; the input register still takes
// one more item, then s_tready drops until the result is taken

module button_press_duration_adjuster #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  // key0_level [0], key1_level [1], now_ticks [33:2], zero [39:34]
  input  logic [bpda_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // control_value [9:0], key0_released [10], key1_released [11],
  // key0_duration [43:12], key1_duration [75:44], key0_down [76], key1_down [77],
  // zero [79:78]
  output logic [bpda_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_we,
  input  logic [bpda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpda_pkg::VALUE_W-1:0] cfg_wdata
);

  localparam int unsigned VW     = bpda_pkg::VALUE_W;
  localparam int unsigned VPAD   = TICK_BITS - VW;
  localparam int unsigned DUR_WS = bpda_pkg::DUR_W;

  // configuration
  logic [VW-1:0] min_value;
  logic [VW-1:0] max_value;

  // input register
  logic                 in_valid;
  logic [1:0]           in_pressed;
  logic [TICK_BITS-1:0] in_now;
  logic [TICK_BITS-1:0] now_ext;

  // key and value state
  bpda_pkg::debounce_t  st [2];
  bpda_pkg::debounce_t  st_next [2];
  logic [TICK_BITS-1:0] press_stamp [2];
  logic [TICK_BITS-1:0] hold_duration [2];
  logic [TICK_BITS-1:0] hold_duration_next [2];
  logic [VW-1:0]        adjusted_value;
  logic [VW-1:0]        adjusted_value_next;

  // per-key machine outputs
  logic [1:0] capture;
  logic [1:0] release_ok;
  logic [1:0] down_next;

  // arithmetic
  logic [VW-1:0]  inc_room;
  logic           inc_over;
  logic [VW-1:0]  v_after_inc;
  logic           dec_under;
  logic [VW-1:0]  dec_diff;
  logic [DUR_WS-1:0] dur_out [2];

  logic advance;

  // handshake: result register free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // tick count taken modulo 2^TICK_BITS
  if (TICK_BITS > bpda_pkg::NOW_W) begin : g_now_wide
    assign now_ext = {{(TICK_BITS - bpda_pkg::NOW_W){1'b0}}, s_tdata[33:2]};
  end else begin : g_now_narrow
    assign now_ext = s_tdata[TICK_BITS+1:2];
  end

  // durations shown as their low 32 bits
  for (genvar k = 0; k < 2; k++) begin : g_dur
    if (TICK_BITS >= DUR_WS) begin : g_cut
      assign dur_out[k] = hold_duration_next[k][DUR_WS-1:0];
    end else begin : g_pad
      assign dur_out[k] = {{(DUR_WS - TICK_BITS){1'b0}}, hold_duration_next[k]};
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= bpda_pkg::RESET_MIN;
      max_value <= bpda_pkg::RESET_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpda_pkg::CFG_MIN_VALUE: min_value <= cfg_wdata;
        bpda_pkg::CFG_MAX_VALUE: max_value <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pressed <= ~s_tdata[1:0];
      in_now     <= now_ext;
    end
  end

  // debouncer next state
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      unique case (st[k])
        bpda_pkg::ST_UP:
          st_next[k] = in_pressed[k] ? bpda_pkg::ST_FALLING : bpda_pkg::ST_UP;
        bpda_pkg::ST_FALLING:
          st_next[k] = in_pressed[k] ? bpda_pkg::ST_DOWN : bpda_pkg::ST_UP;
        bpda_pkg::ST_DOWN:
          st_next[k] = in_pressed[k] ? bpda_pkg::ST_DOWN : bpda_pkg::ST_RISING;
        bpda_pkg::ST_RISING:
          st_next[k] = in_pressed[k] ? bpda_pkg::ST_DOWN : bpda_pkg::ST_UP;
        default:
          st_next[k] = bpda_pkg::ST_UP;
      endcase
    end
  end

  // debouncer outputs: press stamp capture, confirmed release, held flag
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      capture[k]    = (st[k] == bpda_pkg::ST_FALLING) && in_pressed[k];
      release_ok[k] = (st[k] == bpda_pkg::ST_RISING) && !in_pressed[k];
      down_next[k]  = (st_next[k] == bpda_pkg::ST_DOWN) ||
                      (st_next[k] == bpda_pkg::ST_RISING);
    end
  end

  // hold duration as a wrapping difference
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      hold_duration_next[k] = release_ok[k] ? (in_now - press_stamp[k]) : hold_duration[k];
    end
  end

  // key 0 adds with saturation at max, then key 1 subtracts with saturation at min
  always_comb begin
    inc_room    = max_value - adjusted_value;
    inc_over    = (adjusted_value > max_value) ||
                  (hold_duration_next[0] > {{VPAD{1'b0}}, inc_room});
    if (release_ok[0]) begin
      v_after_inc = inc_over ? max_value
                             : adjusted_value + hold_duration_next[0][VW-1:0];
    end else begin
      v_after_inc = adjusted_value;
    end
    dec_under = hold_duration_next[1] > {{VPAD{1'b0}}, v_after_inc};
    dec_diff  = v_after_inc - hold_duration_next[1][VW-1:0];
    if (release_ok[1]) begin
      adjusted_value_next = (dec_under || (dec_diff < min_value)) ? min_value : dec_diff;
    end else begin
      adjusted_value_next = v_after_inc;
    end
  end

  // key state update as the result register loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 2; k++) begin
        st[k]            <= bpda_pkg::ST_UP;
        press_stamp[k]   <= '0;
        hold_duration[k] <= '0;
      end
      adjusted_value <= bpda_pkg::RESET_VALUE;
    end else if (advance) begin
      for (int k = 0; k < 2; k++) begin
        st[k]            <= st_next[k];
        hold_duration[k] <= hold_duration_next[k];
        if (capture[k]) begin
          press_stamp[k] <= in_now;
        end
      end
      adjusted_value <= adjusted_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, down_next[1], down_next[0], dur_out[1], dur_out[0],
                  release_ok[1], release_ok[0], adjusted_value_next};
    end
  end

endmodule

>>> hdl/bpda_checker.sv
`timescale 1ns / 1ps

module bpda_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [bpda_pkg::OUT_DATA_W-1:0] m_tdata
);

  // no result item straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result item present after reset");

  // a stalled result item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result item changed");

  // a confirmed release leaves the increment key up
  a_rel0_up: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[bpda_pkg::O_REL0] |-> !m_tdata[bpda_pkg::O_DOWN0])
    else $error("key 0 released but still down");

  // a confirmed release leaves the decrement key up
  a_rel1_up: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[bpda_pkg::O_REL1] |-> !m_tdata[bpda_pkg::O_DOWN1])
    else $error("key 1 released but still down");

endmodule

bind button_press_duration_adjuster bpda_checker u_bpda_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
